// ----- sv/shp_pkg.sv -----
// ---------------------------------------------------------------------------
// shp_pkg
// Shared types, codes and constants of the stepper homing positioner.
// ---------------------------------------------------------------------------
package shp_pkg;

    // item opcodes
    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_SET_ANGLE = 2'd1,
        OP_ENABLE    = 2'd2,
        OP_DISABLE   = 2'd3
    } opcode_t;

    // run modes, code 3 behaves like RUN_IDLE
    localparam logic [1:0] RUN_MANUAL = 2'd0;
    localparam logic [1:0] RUN_SWEEP  = 2'd1;
    localparam logic [1:0] RUN_IDLE   = 2'd2;

    // microstep modes
    localparam logic [2:0] MS_NONE = 3'd0;
    localparam logic [2:0] MS_400  = 3'd1;
    localparam logic [2:0] MS_800  = 3'd2;
    localparam logic [2:0] MS_1600 = 3'd3;
    localparam logic [2:0] MS_3200 = 3'd4;

    // configuration register indexes
    localparam logic CFG_MICROSTEP = 1'b0;
    localparam logic CFG_RUN_MODE  = 1'b1;

    localparam int FULL_BASE     = 1600;
    localparam int ANGLE_MAX     = 180;
    localparam int START_PERIOD  = 200;
    localparam int RAMP_INTERVAL = 50;

    // x/9 as (x * DIV9_MUL) >> DIV9_SHIFT, exact for x < 2**15
    localparam int DIV9_MUL   = 29128;
    localparam int DIV9_SHIFT = 18;

    localparam int POS_W    = 13;
    localparam int PERIOD_W = 8;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] target_angle;
        logic       sensor_blocked;
    } item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic signed [POS_W-1:0] target;
        logic [PERIOD_W-1:0]     period;
        logic                    homed;
        logic                    done;
        logic                    dir;
        logic                    pulse;
        logic                    run;
    } state_t;

    function automatic logic signed [POS_W-1:0] full_scale(input logic [2:0] mode);
        logic signed [POS_W-1:0] f;
        unique case (mode)
            MS_400:  f = POS_W'(FULL_BASE / 4);
            MS_800:  f = POS_W'(FULL_BASE / 2);
            MS_1600: f = POS_W'(FULL_BASE);
            MS_3200: f = POS_W'(FULL_BASE * 2);
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ----- sv/shp_in_stage.sv -----
// ---------------------------------------------------------------------------
// shp_in_stage
// Input register of the positioner: holds one accepted item until the
// step logic consumes it.
// ---------------------------------------------------------------------------
module shp_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  shp_pkg::item_t item_i,
    input  logic           take_i,
    output logic           valid_o,
    output shp_pkg::item_t item_o
);

    logic           valid_reg;
    logic           valid_next;
    shp_pkg::item_t item_reg;

    // a slot frees up in the same cycle the held item is consumed
    assign s_tready   = !valid_reg || take_i;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take_i);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_i;
        end
    end

    assign valid_o = valid_reg;
    assign item_o  = item_reg;

endmodule

// ----- sv/shp_step.sv -----
// ---------------------------------------------------------------------------
// shp_step
// Next-state logic for one item: homing, sweep and manual stepping,
// speed ramp and set-angle target computation.
// ---------------------------------------------------------------------------
module shp_step #(
    parameter int  START_PERIOD  = shp_pkg::START_PERIOD,
    parameter int  RAMP_INTERVAL = shp_pkg::RAMP_INTERVAL,
    localparam int RES_W         = (RAMP_INTERVAL > 1) ? $clog2(RAMP_INTERVAL) : 1
) (
    input  shp_pkg::state_t state_i,
    input  logic [RES_W-1:0] res_i,
    input  shp_pkg::item_t  item_i,
    input  logic [2:0]      microstep_mode_i,
    input  logic [1:0]      run_mode_i,
    output shp_pkg::state_t state_o,
    output logic [RES_W-1:0] res_o
);

    localparam int POS_W = shp_pkg::POS_W;

    // residues of fixed positions modulo the ramp interval
    localparam logic [RES_W-1:0] RES_TOP     = RES_W'(RAMP_INTERVAL - 1);
    localparam logic [RES_W-1:0] RES_WRAP_UP =
        RES_W'((RAMP_INTERVAL - (4096 % RAMP_INTERVAL)) % RAMP_INTERVAL);
    localparam logic [RES_W-1:0] RES_WRAP_DN = RES_W'(4095 % RAMP_INTERVAL);
    localparam logic [RES_W-1:0] RES_H400    = RES_W'((shp_pkg::FULL_BASE / 8) % RAMP_INTERVAL);
    localparam logic [RES_W-1:0] RES_H800    = RES_W'((shp_pkg::FULL_BASE / 4) % RAMP_INTERVAL);
    localparam logic [RES_W-1:0] RES_H1600   = RES_W'((shp_pkg::FULL_BASE / 2) % RAMP_INTERVAL);
    localparam logic [RES_W-1:0] RES_H3200   = RES_W'(shp_pkg::FULL_BASE % RAMP_INTERVAL);

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [7:0] PERIOD_START = 8'(START_PERIOD);

    logic signed [POS_W-1:0] full;
    logic signed [POS_W-1:0] half;
    logic [RES_W-1:0]        res_half;
    logic                    tick_go;
    logic                    home_now;
    logic                    dir_a;
    logic signed [POS_W-1:0] pos_a;
    logic [RES_W-1:0]        res_a;
    logic signed [POS_W-1:0] pos1;
    logic [RES_W-1:0]        res1;
    logic [7:0]              angle_c;
    logic [11:0]             angle_x20;
    logic [14:0]             scaled;
    logic [29:0]             prod;
    logic signed [POS_W-1:0] target_new;

    assign full = shp_pkg::full_scale(microstep_mode_i);
    assign half = full >>> 1;

    always_comb begin
        unique case (microstep_mode_i)
            shp_pkg::MS_400:  res_half = RES_H400;
            shp_pkg::MS_800:  res_half = RES_H800;
            shp_pkg::MS_1600: res_half = RES_H1600;
            shp_pkg::MS_3200: res_half = RES_H3200;
            default:          res_half = '0;
        endcase
    end

    // homing part of a tick
    assign tick_go  = (item_i.opcode == shp_pkg::OP_TICK) && state_i.run;
    assign home_now = tick_go && !state_i.homed && item_i.sensor_blocked;
    assign dir_a    = (tick_go && !state_i.homed) ? 1'b1 : state_i.dir;
    assign pos_a    = home_now ? half : state_i.pos;
    assign res_a    = home_now ? res_half : res_i;

    // one step in the current direction, residue tracked alongside
    always_comb begin
        if (dir_a) begin
            pos1 = pos_a - POS_W'(1);
            if (pos_a == POS_MIN) begin
                res1 = RES_WRAP_DN;
            end else if (res_a == '0) begin
                res1 = RES_TOP;
            end else begin
                res1 = res_a - RES_W'(1);
            end
        end else begin
            pos1 = pos_a + POS_W'(1);
            if (pos_a == POS_MAX) begin
                res1 = RES_WRAP_UP;
            end else if (res_a == RES_TOP) begin
                res1 = '0;
            end else begin
                res1 = res_a + RES_W'(1);
            end
        end
    end

    // target = angle * full / 180 = angle * 20 * 2**k / 9
    assign angle_c   = (item_i.target_angle > 8'(shp_pkg::ANGLE_MAX)) ?
                       8'(shp_pkg::ANGLE_MAX) : item_i.target_angle;
    assign angle_x20 = {angle_c, 4'b0000} + {2'b00, angle_c, 2'b00};

    always_comb begin
        unique case (microstep_mode_i)
            shp_pkg::MS_400:  scaled = {3'b000, angle_x20};
            shp_pkg::MS_800:  scaled = {2'b00, angle_x20, 1'b0};
            shp_pkg::MS_1600: scaled = {1'b0, angle_x20, 2'b00};
            shp_pkg::MS_3200: scaled = {angle_x20, 3'b000};
            default:          scaled = '0;
        endcase
    end

    assign prod       = 30'(scaled) * 30'(shp_pkg::DIV9_MUL);
    assign target_new = {1'b0, prod[shp_pkg::DIV9_SHIFT +: POS_W-1]};

    always_comb begin
        state_o = state_i;
        res_o   = res_i;
        unique case (item_i.opcode)
            shp_pkg::OP_TICK: begin
                if (state_i.run) begin
                    state_o.pulse = ~state_i.pulse;
                    state_o.dir   = dir_a;
                    state_o.pos   = pos_a;
                    res_o         = res_a;
                    if (!state_i.homed) begin
                        state_o.done = home_now;
                    end
                    if (home_now) begin
                        state_o.homed = 1'b1;
                        state_o.run   = 1'b0;
                    end
                    if (state_i.homed || home_now) begin
                        if (run_mode_i == shp_pkg::RUN_SWEEP) begin
                            state_o.pos = pos1;
                            res_o       = res1;
                            // both flips at once cancel out
                            state_o.dir = dir_a ^ (pos1 >= full) ^ (pos1 == '0);
                        end else if (run_mode_i == shp_pkg::RUN_MANUAL) begin
                            state_o.pos  = pos1;
                            res_o        = res1;
                            state_o.done = 1'b0;
                            if (res1 == '0 && state_i.period > 8'd1) begin
                                state_o.period = state_i.period - 8'd1;
                            end
                            if (pos1 == state_i.target) begin
                                state_o.done = 1'b1;
                                state_o.run  = 1'b0;
                            end
                        end
                    end
                end
            end
            shp_pkg::OP_SET_ANGLE: begin
                if (run_mode_i == shp_pkg::RUN_MANUAL) begin
                    state_o.target = target_new;
                    if (target_new > state_i.pos) begin
                        state_o.dir    = 1'b0;
                        state_o.run    = 1'b1;
                        state_o.period = PERIOD_START;
                    end else if (target_new < state_i.pos) begin
                        state_o.dir    = 1'b1;
                        state_o.run    = 1'b1;
                        state_o.period = PERIOD_START;
                    end else begin
                        state_o.run = 1'b0;
                    end
                end
            end
            shp_pkg::OP_ENABLE: begin
                state_o.run    = 1'b1;
                state_o.period = PERIOD_START;
            end
            shp_pkg::OP_DISABLE: begin
                state_o.run = 1'b0;
            end
            default: begin
                state_o = state_i;
            end
        endcase
    end

endmodule

// ----- sv/stepper_homing_positioner.sv -----
// ---------------------------------------------------------------------------
// stepper_homing_positioner
// Stepper position controller with homing, sweep and manual positioning.
// ---------------------------------------------------------------------------
//   channel   direction  signals                          contents
//   s_        in         s_tvalid/s_tready/s_tdata/s_tuser tick or command
//   m_        out        m_tvalid/m_tready/m_tdata        state after the item
//   cfg_      in         cfg_we/cfg_addr/cfg_wdata        microstep, run mode
//
// one item per clock sustained while results are taken; each item passes
// through registers in order: the input transfer loads the input register,
// then the step logic loads the result register
// the state registers update when the step logic consumes an item
// a stalled result holds the result register; one more item waits in the
// input register, after which s_tready drops
// aresetn is synchronous, active low
// ---------------------------------------------------------------------------
module stepper_homing_positioner #(
    parameter int START_PERIOD  = shp_pkg::START_PERIOD,
    parameter int RAMP_INTERVAL = shp_pkg::RAMP_INTERVAL
) (
    input  logic        aclk,
    input  logic        aresetn,
    // [7:0] target_angle, [8] sensor_blocked
    input  logic [15:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [12:0] position, [13] direction, [14] pulse_level, [15] finished,
    // [16] homed, [17] running, [25:18] step_period
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [2:0]  cfg_wdata
);

    localparam int RES_W = (RAMP_INTERVAL > 1) ? $clog2(RAMP_INTERVAL) : 1;

    shp_pkg::item_t  in_item;
    shp_pkg::item_t  cur_item;
    logic            cur_valid;
    logic            fire;

    shp_pkg::state_t state_reg;
    shp_pkg::state_t state_next;
    logic [RES_W-1:0] res_reg;
    logic [RES_W-1:0] res_next;

    logic [2:0]  microstep_mode_reg;
    logic [1:0]  run_mode_reg;

    logic        m_valid_reg;
    logic        m_valid_next;
    logic [31:0] m_data_reg;

    assign in_item.opcode         = shp_pkg::opcode_t'(s_tuser);
    assign in_item.target_angle   = s_tdata[7:0];
    assign in_item.sensor_blocked = s_tdata[8];

    shp_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .item_i   (in_item),
        .take_i   (fire),
        .valid_o  (cur_valid),
        .item_o   (cur_item)
    );

    shp_step #(
        .START_PERIOD  (START_PERIOD),
        .RAMP_INTERVAL (RAMP_INTERVAL)
    ) u_step (
        .state_i          (state_reg),
        .res_i            (res_reg),
        .item_i           (cur_item),
        .microstep_mode_i (microstep_mode_reg),
        .run_mode_i       (run_mode_reg),
        .state_o          (state_next),
        .res_o            (res_next)
    );

    assign fire         = cur_valid && (!m_valid_reg || m_tready);
    assign m_valid_next = fire || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            microstep_mode_reg <= shp_pkg::MS_1600;
            run_mode_reg       <= shp_pkg::RUN_IDLE;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                shp_pkg::CFG_MICROSTEP: microstep_mode_reg <= cfg_wdata;
                shp_pkg::CFG_RUN_MODE:  run_mode_reg       <= cfg_wdata[1:0];
                default:                run_mode_reg       <= run_mode_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.pos    <= '0;
            state_reg.target <= '0;
            state_reg.period <= 8'(START_PERIOD);
            state_reg.homed  <= 1'b0;
            state_reg.done   <= 1'b0;
            state_reg.dir    <= 1'b0;
            state_reg.pulse  <= 1'b0;
            state_reg.run    <= 1'b1;
            res_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (fire) begin
                state_reg <= state_next;
                res_reg   <= res_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= {6'b000000, state_next.period, state_next.run, state_next.homed,
                           state_next.done, state_next.pulse, state_next.dir,
                           state_next.pos};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- sv/shp_checker.sv -----
// ---------------------------------------------------------------------------
// shp_checker
// Port-level assertions for the stepper homing positioner.
// ---------------------------------------------------------------------------
module shp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    logic seen_homed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_homed_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tdata[16]) begin
            seen_homed_reg <= 1'b1;
        end
    end

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // once homed, every later result stays homed
    a_homed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_homed_reg |-> m_tdata[16])
        else $error("homed flag dropped");

    // ramp never takes the period to zero
    a_period_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[25:18] != 8'd0)
        else $error("step period reached zero");

    // a result from an empty output comes from an input transfer, through the input register
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching input transfer");

endmodule

bind stepper_homing_positioner shp_checker u_shp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ----- dv/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for stepper_homing_positioner: a table of directed
// items covers homing, every opcode and the odd register codes, then random
// phases of manual moves, sweeps and noise run under changing idle patterns.
// Every result transfer is compared field by field against an in-bench
// controller model, or against the expected status of a typed table row.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int          STALL_LIMIT  = 2000;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          PHASES       = 12;
    localparam int          PHASE_QUOTA  = 140;
    // codes outside the documented range: 7 decodes as MS_NONE, 3 as RUN_IDLE
    localparam logic [2:0]  MS_BEYOND    = 3'd7;
    localparam logic [1:0]  RUN_IDLE_ALT = 2'd3;

    // laid out as m_tdata[25:0], msb first
    typedef struct packed {
        logic [shp_pkg::PERIOD_W-1:0]     period;
        logic                             running;
        logic                             homed;
        logic                             finished;
        logic                             pulse;
        logic                             direction;
        logic signed [shp_pkg::POS_W-1:0] position;
    } status_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic             reg_idx;
        logic [2:0]       reg_val;
        shp_pkg::opcode_t op;
        logic [7:0]       angle;
        logic             sensor;
        bit               typed;
        status_t          want;
    } plan_row_t;

    localparam status_t NO_STATUS = '0;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = shp_pkg::OP_TICK;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = shp_pkg::CFG_MICROSTEP;
    logic [2:0]  cfg_wdata = '0;

    // controller model state
    logic signed [shp_pkg::POS_W-1:0] ctl_pos;
    logic signed [shp_pkg::POS_W-1:0] ctl_target;
    logic [shp_pkg::PERIOD_W-1:0]     ctl_period;
    logic                             ctl_homed, ctl_done, ctl_dir, ctl_pulse, ctl_run;
    logic [2:0]                       ctl_ms;
    logic [1:0]                       ctl_rm;

    status_t pending_status [$];

    int mismatches      = 0;
    int items_sent      = 0;
    int effective_items = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int pos_lo          = 0;
    int pos_hi          = 0;
    int send_idle_pct   = 12;
    int recv_idle_pct   = 54;
    int stall_cycles    = 0;
    int hold_left       = 0;
    bit hold_request    = 1'b0;
    bit hold_taken      = 1'b0;

    plan_row_t directed_plan [35] = '{
        // field order of expected status: period, run, homed, fin, pulse, dir, pos
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b0, 1'b1,
          '{8'd200, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 13'sd0}},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_DISABLE, 8'd0, 1'b0, 1'b1,
          '{8'd200, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 13'sd0}},
        // tick while stopped, sensor blocked: nothing moves
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b1, 1'b1,
          '{8'd200, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 13'sd0}},
        // set angle outside manual mode is dropped
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_SET_ANGLE, 8'd90, 1'b0, 1'b1,
          '{8'd200, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 13'sd0}},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_ENABLE, 8'd0, 1'b0, 1'b1,
          '{8'd200, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 13'sd0}},
        // home found: half of 1600, finished, stopped
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b1, 1'b1,
          '{8'd200, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 13'sd800}},
        '{ROW_CFG, shp_pkg::CFG_RUN_MODE, 3'(shp_pkg::RUN_MANUAL), shp_pkg::OP_TICK,
          8'd0, 1'b0, 1'b0, NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_SET_ANGLE, 8'd180, 1'b0, 1'b1,
          '{8'd200, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 13'sd800}},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b0, 1'b1,
          '{8'd200, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 13'sd801}},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_SET_ANGLE, 8'd0, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b1, 1'b0,
          NO_STATUS},
        // target equals position: stop
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_SET_ANGLE, 8'd90, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b0, 1'b0,
          NO_STATUS},
        // angle above 180 clamps
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_SET_ANGLE, 8'd255, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_CFG, shp_pkg::CFG_MICROSTEP, MS_BEYOND, shp_pkg::OP_TICK, 8'd0, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_SET_ANGLE, 8'd120, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_CFG, shp_pkg::CFG_MICROSTEP, shp_pkg::MS_3200, shp_pkg::OP_TICK, 8'd0,
          1'b0, 1'b0, NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_SET_ANGLE, 8'd180, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_CFG, shp_pkg::CFG_MICROSTEP, shp_pkg::MS_800, shp_pkg::OP_TICK, 8'd0,
          1'b0, 1'b0, NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_SET_ANGLE, 8'd45, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b1, 1'b0,
          NO_STATUS},
        '{ROW_CFG, shp_pkg::CFG_MICROSTEP, shp_pkg::MS_400, shp_pkg::OP_TICK, 8'd0,
          1'b0, 1'b0, NO_STATUS},
        '{ROW_CFG, shp_pkg::CFG_RUN_MODE, 3'(shp_pkg::RUN_SWEEP), shp_pkg::OP_TICK, 8'd0,
          1'b0, 1'b0, NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_ENABLE, 8'd0, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b1, 1'b0,
          NO_STATUS},
        '{ROW_CFG, shp_pkg::CFG_RUN_MODE, 3'(RUN_IDLE_ALT), shp_pkg::OP_TICK, 8'd0,
          1'b0, 1'b0, NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_CFG, shp_pkg::CFG_MICROSTEP, shp_pkg::MS_NONE, shp_pkg::OP_TICK, 8'd0,
          1'b0, 1'b0, NO_STATUS},
        '{ROW_CFG, shp_pkg::CFG_RUN_MODE, 3'(shp_pkg::RUN_IDLE), shp_pkg::OP_TICK, 8'd0,
          1'b0, 1'b0, NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_TICK, 8'd0, 1'b0, 1'b0,
          NO_STATUS},
        '{ROW_ITEM, shp_pkg::CFG_MICROSTEP, 3'd0, shp_pkg::OP_DISABLE, 8'd0, 1'b0, 1'b0,
          NO_STATUS}
    };

    logic [2:0] phase_ms [PHASES] = '{
        shp_pkg::MS_3200, shp_pkg::MS_400, shp_pkg::MS_NONE, shp_pkg::MS_800,
        shp_pkg::MS_1600, MS_BEYOND, shp_pkg::MS_3200, shp_pkg::MS_400,
        shp_pkg::MS_800, shp_pkg::MS_1600, shp_pkg::MS_NONE, shp_pkg::MS_400};
    logic [1:0] phase_rm [PHASES] = '{
        shp_pkg::RUN_MANUAL, shp_pkg::RUN_SWEEP, shp_pkg::RUN_MANUAL, shp_pkg::RUN_SWEEP,
        shp_pkg::RUN_IDLE, shp_pkg::RUN_MANUAL, shp_pkg::RUN_SWEEP, shp_pkg::RUN_MANUAL,
        RUN_IDLE_ALT, shp_pkg::RUN_SWEEP, shp_pkg::RUN_MANUAL, shp_pkg::RUN_MANUAL};

    stepper_homing_positioner dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int steps_per_turn(logic [2:0] ms);
        case (ms)
            shp_pkg::MS_400:  return shp_pkg::FULL_BASE / 4;
            shp_pkg::MS_800:  return shp_pkg::FULL_BASE / 2;
            shp_pkg::MS_1600: return shp_pkg::FULL_BASE;
            shp_pkg::MS_3200: return shp_pkg::FULL_BASE * 2;
            default:          return 0;
        endcase
    endfunction

    function automatic void step_one();
        ctl_pos = ctl_dir ? ctl_pos - 13'sd1 : ctl_pos + 13'sd1;
    endfunction

    function automatic void start_motion();
        ctl_run    = 1'b1;
        ctl_period = shp_pkg::PERIOD_W'(shp_pkg::START_PERIOD);
    endfunction

    // state after one item; acted is low when the item changes nothing
    function automatic status_t advance_controller(input shp_pkg::opcode_t op,
                                                   input logic [7:0] angle,
                                                   input logic sensor, output bit acted);
        int full;
        int ang;
        int tgt;
        full  = steps_per_turn(ctl_ms);
        acted = 1'b1;
        case (op)
            shp_pkg::OP_TICK: begin
                if (!ctl_run) begin
                    acted = 1'b0;
                end else begin
                    ctl_pulse = !ctl_pulse;
                    if (!ctl_homed) begin
                        ctl_dir  = 1'b1;
                        ctl_done = 1'b0;
                        if (sensor) begin
                            ctl_homed = 1'b1;
                            ctl_pos   = shp_pkg::POS_W'(full / 2);
                            ctl_done  = 1'b1;
                            ctl_run   = 1'b0;
                        end
                    end
                    // the homing tick still gets one step of the run mode
                    if (ctl_homed && ctl_rm == shp_pkg::RUN_SWEEP) begin
                        step_one();
                        if (int'(ctl_pos) >= full) ctl_dir = !ctl_dir;
                        if (ctl_pos == 0) ctl_dir = !ctl_dir;
                    end else if (ctl_homed && ctl_rm == shp_pkg::RUN_MANUAL) begin
                        ctl_done = 1'b0;
                        step_one();
                        if (int'(ctl_pos) % shp_pkg::RAMP_INTERVAL == 0 && ctl_period > 1)
                            ctl_period = ctl_period - 1'b1;
                        if (ctl_pos == ctl_target) begin
                            ctl_done = 1'b1;
                            ctl_run  = 1'b0;
                        end
                    end
                end
            end
            shp_pkg::OP_SET_ANGLE: begin
                if (ctl_rm != shp_pkg::RUN_MANUAL) begin
                    acted = 1'b0;
                end else begin
                    ang        = (int'(angle) > shp_pkg::ANGLE_MAX) ?
                                 shp_pkg::ANGLE_MAX : int'(angle);
                    tgt        = ang * full / shp_pkg::ANGLE_MAX;
                    ctl_target = shp_pkg::POS_W'(tgt);
                    if (tgt > int'(ctl_pos)) begin
                        ctl_dir = 1'b0;
                        start_motion();
                    end else if (tgt < int'(ctl_pos)) begin
                        ctl_dir = 1'b1;
                        start_motion();
                    end else begin
                        ctl_run = 1'b0;
                    end
                end
            end
            shp_pkg::OP_ENABLE: start_motion();
            default: begin
                acted   = ctl_run;
                ctl_run = 1'b0;
            end
        endcase
        return '{ctl_period, ctl_run, ctl_homed, ctl_done, ctl_pulse, ctl_dir, ctl_pos};
    endfunction

    function automatic void check_status(status_t got);
        status_t want;
        if (pending_status.size() == 0) begin
            $error("result transfer with nothing pending: %h", got);
            mismatches++;
            return;
        end
        want = pending_status.pop_front();
        results_checked++;
        if (int'(got.position) < pos_lo) pos_lo = int'(got.position);
        if (int'(got.position) > pos_hi) pos_hi = int'(got.position);
        if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            mismatches++;
        end
        if (got.direction !== want.direction) begin
            $error("direction: expected %0d, got %0d", want.direction, got.direction);
            mismatches++;
        end
        if (got.pulse !== want.pulse) begin
            $error("pulse_level: expected %0d, got %0d", want.pulse, got.pulse);
            mismatches++;
        end
        if (got.finished !== want.finished) begin
            $error("finished: expected %0d, got %0d", want.finished, got.finished);
            mismatches++;
        end
        if (got.homed !== want.homed) begin
            $error("homed: expected %0d, got %0d", want.homed, got.homed);
            mismatches++;
        end
        if (got.running !== want.running) begin
            $error("running: expected %0d, got %0d", want.running, got.running);
            mismatches++;
        end
        if (got.period !== want.period) begin
            $error("step_period: expected %0d, got %0d", want.period, got.period);
            mismatches++;
        end
    endfunction

    // result side: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) check_status(status_t'(m_tdata[25:0]));
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (hold_request && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // called in the step of the previous transfer, so valid gets one assignment
    task automatic send_item(shp_pkg::opcode_t op, logic [7:0] angle, logic sensor,
                             bit typed = 1'b0, status_t want = '0);
        status_t predicted;
        bit      acted;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, sensor, angle};
        do @(posedge aclk); while (!s_tready);
        predicted = advance_controller(op, angle, sensor, acted);
        pending_status.push_back(typed ? want : predicted);
        items_sent++;
        if (acted) effective_items++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [2:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == shp_pkg::CFG_MICROSTEP) ctl_ms = val;
        else ctl_rm = val[1:0];
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic send_noise();
        send_item(shp_pkg::opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(logic [2:0] ms, logic [1:0] rm);
        int start;
        int full;
        int near;
        int n;
        drain_results();
        write_reg(shp_pkg::CFG_MICROSTEP, ms);
        write_reg(shp_pkg::CFG_RUN_MODE, 3'(rm));
        start = effective_items;
        while (effective_items - start < PHASE_QUOTA) begin
            full = steps_per_turn(ctl_ms);
            if (rm == shp_pkg::RUN_MANUAL && $urandom_range(0, 9) < 7) begin
                // mostly short moves around the current angle
                if (full > 0 && $urandom_range(0, 4) != 0) begin
                    near = int'(ctl_pos) * shp_pkg::ANGLE_MAX / full
                           + int'($urandom_range(0, 10)) - 5;
                    if (near < 0) near = 0;
                    if (near > shp_pkg::ANGLE_MAX) near = shp_pkg::ANGLE_MAX;
                end else begin
                    near = $urandom_range(0, 255);
                end
                send_item(shp_pkg::OP_SET_ANGLE, 8'(near), 1'($urandom_range(0, 1)));
                n = 0;
                while (ctl_run && n < 80) begin
                    send_item(shp_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                    n++;
                end
            end else if (rm == shp_pkg::RUN_SWEEP && $urandom_range(0, 9) < 6) begin
                if (!ctl_run) send_item(shp_pkg::OP_ENABLE, 8'd0, 1'b0);
                repeat ($urandom_range(5, 120))
                    send_item(shp_pkg::OP_TICK, 8'd0, 1'($urandom_range(0, 1)));
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        ctl_pos    = '0;
        ctl_target = '0;
        ctl_period = shp_pkg::PERIOD_W'(shp_pkg::START_PERIOD);
        ctl_homed  = 1'b0;
        ctl_done   = 1'b0;
        ctl_dir    = 1'b0;
        ctl_pulse  = 1'b0;
        ctl_run    = 1'b1;
        ctl_ms     = shp_pkg::MS_1600;
        ctl_rm     = shp_pkg::RUN_IDLE;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_CFG) begin
                drain_results();
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
            end else begin
                send_item(directed_plan[i].op, directed_plan[i].angle, directed_plan[i].sensor,
                          directed_plan[i].typed, directed_plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p < 4) begin
                send_idle_pct = 12;
                recv_idle_pct = 54;
            end else if (p < 8) begin
                send_idle_pct = 54;
                recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 1) hold_request = 1'b1;
            run_phase(phase_ms[p], phase_rm[p]);
        end

        drain_results();
        $display("covered %0d items (%0d took effect), %0d results checked, %0d register writes",
                 items_sent, effective_items, results_checked, reg_writes);
        $display("homing, manual moves, sweeps and idle run modes seen, position %0d to %0d",
                 pos_lo, pos_hi);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
